// ----- src/sfd_pkg.sv -----
// Shared types and constants for the sensor frame deframer.
package sfd_pkg;

  // Largest number of bytes one frame may hold before it is dropped.
  localparam int MAX_FRAME_BYTES = 512;

  // Byte counter width: it must be able to hold MAX_FRAME_BYTES itself.
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 9;
  localparam int LEN_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_FIRST  = 2'd0,
    CFG_HEADER_SECOND = 2'd1,
    CFG_TAIL_FIRST    = 2'd2,
    CFG_TAIL_SECOND   = 2'd3
  } cfg_idx_t;

  // Kinds of result word.
  typedef enum logic [1:0] {
    EV_PAYLOAD  = 2'd0,
    EV_COMPLETE = 2'd1,
    EV_BAD_TAIL = 2'd2,
    EV_OVERFLOW = 2'd3
  } event_kind_t;

  // Current framing bytes.
  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
    logic [BYTE_W-1:0] tail_first;
    logic [BYTE_W-1:0] tail_second;
  } cfg_t;

  // One received word.
  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              response_expected;
  } in_word_t;

  // One result word.
  typedef struct packed {
    event_kind_t        event_kind;
    logic [BYTE_W-1:0]  frame_control;
    logic [BYTE_W-1:0]  frame_command;
    logic [BYTE_W-1:0]  payload_byte;
    logic [INDEX_W-1:0] payload_index;
    logic [LEN_W-1:0]   payload_length;
    logic               checksum_ok;
    logic               to_response;
  } out_word_t;

endpackage

// ----- src/sfd_cfg.sv -----
// Configuration registers holding the header and tail bytes.
module sfd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output sfd_pkg::cfg_t                  cfg
);
  import sfd_pkg::*;

  cfg_t cfg_r;

  // Register writes; reset loads the default framing bytes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= 8'h53;
      cfg_r.header_second <= 8'h59;
      cfg_r.tail_first    <= 8'h54;
      cfg_r.tail_second   <= 8'h43;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_HEADER_FIRST:  cfg_r.header_first  <= cfg_data;
        CFG_HEADER_SECOND: cfg_r.header_second <= cfg_data;
        CFG_TAIL_FIRST:    cfg_r.tail_first    <= cfg_data;
        CFG_TAIL_SECOND:   cfg_r.tail_second   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/sfd_core.sv -----
// Frame parser: byte position, held header fields, checksum and result decode.
module sfd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  sfd_pkg::cfg_t      cfg,
  input  logic               in_fire,
  input  sfd_pkg::in_word_t  in_word,
  output logic               push,
  output sfd_pkg::out_word_t push_word
);
  import sfd_pkg::*;

  localparam logic [POS_W-1:0] POS_SECOND  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CONTROL = POS_W'(2);
  localparam logic [POS_W-1:0] POS_COMMAND = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(6);
  localparam logic [POS_W-1:0] POS_MAX     = POS_W'(MAX_FRAME_BYTES);
  localparam logic [LEN_W-1:0] LEN_FIT_MAX = LEN_W'(MAX_FRAME_BYTES - 9);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] control_r, control_nxt;
  logic [BYTE_W-1:0] command_r, command_nxt;
  logic [LEN_W-1:0]  length_r, length_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] rsum_r, rsum_nxt;
  logic              tfs_r, tfs_nxt;

  logic [BYTE_W-1:0] b;
  logic [POS_W-1:0]  pos_inc;
  logic [LEN_W:0]    idx_ext;
  logic [LEN_W:0]    inc_ext;
  logic [LEN_W:0]    len_ext;
  logic              in_payload;
  logic              at_checksum;
  logic              at_tail_first;
  logic              frame_done;
  logic              have_result;
  event_kind_t       kind;

  assign b       = in_word.rx_byte;
  assign pos_inc = pos_r + POS_W'(1);
  assign idx_ext = (LEN_W + 1)'(pos_r);
  assign inc_ext = (LEN_W + 1)'(pos_inc);
  assign len_ext = {1'b0, length_r};

  // Where the current byte falls relative to the payload length.
  assign in_payload    = idx_ext < (len_ext + (LEN_W + 1)'(6));
  assign at_checksum   = idx_ext == (len_ext + (LEN_W + 1)'(6));
  assign at_tail_first = idx_ext == (len_ext + (LEN_W + 1)'(7));
  assign frame_done    = (inc_ext >= (len_ext + (LEN_W + 1)'(9))) &&
                         (length_r <= LEN_FIT_MAX);

  // Next state and result for the accepted byte.
  always_comb begin
    pos_nxt     = pos_r;
    control_nxt = control_r;
    command_nxt = command_r;
    length_nxt  = length_r;
    sum_nxt     = sum_r;
    rsum_nxt    = rsum_r;
    tfs_nxt     = tfs_r;
    have_result = 1'b0;
    kind        = EV_PAYLOAD;

    if (pos_r == '0) begin
      // Hunting for the first header byte.
      if (b == cfg.header_first) begin
        sum_nxt = b;
        tfs_nxt = 1'b0;
        pos_nxt = POS_SECOND;
      end
    end else if (pos_r == POS_SECOND) begin
      // Second header byte, or resynchronize on a repeated first byte.
      if (b == cfg.header_second) begin
        sum_nxt = sum_r + b;
        pos_nxt = POS_CONTROL;
      end else if (b == cfg.header_first) begin
        sum_nxt = b;
        tfs_nxt = 1'b0;
        pos_nxt = POS_SECOND;
      end else begin
        pos_nxt = '0;
      end
    end else if (pos_r < POS_PAYLOAD) begin
      // Control, command and big-endian length bytes.
      pos_nxt = pos_inc;
      sum_nxt = sum_r + b;
      if (pos_r == POS_CONTROL) begin
        control_nxt = b;
      end else if (pos_r == POS_COMMAND) begin
        command_nxt = b;
      end else if (pos_r == POS_LEN_HI) begin
        length_nxt = {b, 8'h00};
      end else begin
        length_nxt = {length_r[LEN_W-1:8], b};
      end
    end else begin
      // Payload, checksum and tail bytes.
      pos_nxt = pos_inc;
      if (in_payload) begin
        sum_nxt     = sum_r + b;
        have_result = 1'b1;
        kind        = EV_PAYLOAD;
      end else if (at_checksum) begin
        rsum_nxt = b;
      end else if (at_tail_first) begin
        tfs_nxt = (b == cfg.tail_first);
      end
      if (frame_done) begin
        have_result = 1'b1;
        kind        = (tfs_r && (b == cfg.tail_second)) ? EV_COMPLETE : EV_BAD_TAIL;
        pos_nxt     = '0;
      end else if (pos_inc >= POS_MAX) begin
        // Buffer limit reached: drop the frame and hunt again.
        pos_nxt = '0;
        if (have_result) begin
          kind = EV_OVERFLOW;
        end
      end
    end
  end

  // Result word assembly.
  always_comb begin
    push_word.event_kind     = kind;
    push_word.frame_control  = control_r;
    push_word.frame_command  = command_r;
    push_word.payload_length = length_r;
    push_word.payload_byte   = (kind == EV_PAYLOAD) ? b : '0;
    push_word.payload_index  = (kind == EV_PAYLOAD) ? INDEX_W'(pos_r - POS_PAYLOAD) : '0;
    push_word.checksum_ok    = (kind == EV_COMPLETE) && (sum_r == rsum_r);
    push_word.to_response    = (kind == EV_COMPLETE) && in_word.response_expected;
  end

  assign push = in_fire && have_result;

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      control_r <= '0;
      command_r <= '0;
      length_r  <= '0;
      sum_r     <= '0;
      rsum_r    <= '0;
      tfs_r     <= 1'b0;
    end else if (in_fire) begin
      pos_r     <= pos_nxt;
      control_r <= control_nxt;
      command_r <= command_nxt;
      length_r  <= length_nxt;
      sum_r     <= sum_nxt;
      rsum_r    <= rsum_nxt;
      tfs_r     <= tfs_nxt;
    end
  end

endmodule

// ----- src/sfd_skid.sv -----
// Two-entry output buffer: result register plus a skid register.
module sfd_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sfd_pkg::out_word_t push_word,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output sfd_pkg::out_word_t out_data
);
  import sfd_pkg::*;

  logic      out_valid_r;
  logic      skid_valid_r;
  out_word_t out_data_r;
  out_word_t skid_data_r;

  // New words are taken only while the skid register is empty.
  assign can_push = !skid_valid_r;

  // The result register reloads whenever it is empty or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Data path of the two entries.
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_word;
    end else if (push) begin
      skid_data_r <= push_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/sensor_frame_deframer.sv -----
// Top level of the sensor frame deframer.
// The deframer takes one received byte per word and can accept a word on every
// clock cycle while in_ready is high. Each byte is parsed in the cycle it is
// accepted, and any result word it causes is registered in the result register
// or, while the consumer holds off, in the skid register behind it, which holds
// one more word. in_ready is low only while both registers are full, and that
// happens only after the consumer has stalled with a result waiting.
// Hunted bytes, header, length, checksum and first tail bytes produce no result.
// Each payload byte produces one result, and the last tail byte produces the
// frame verdict. A frame that reaches the buffer limit is dropped, with an
// overflow word in place of the payload word for that byte.
// Framing bytes are written through the cfg_ port and should be changed only
// while no frame is in progress.
module sensor_frame_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sfd_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sfd_pkg::out_word_t             out_data,
  input  logic                           cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfd_pkg::*;

  cfg_t      cfg;
  logic      in_fire;
  logic      push;
  out_word_t push_word;

  assign in_fire = in_valid && in_ready;

  // Framing byte registers.
  sfd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // Byte parser.
  sfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .in_word   (in_data),
    .push      (push),
    .push_word (push_word)
  );

  // Result buffer.
  sfd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- src/sfd_checker.sv -----
// Port-level checks for the sensor frame deframer, bound to the top level.
module sfd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input sfd_pkg::in_word_t              in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input sfd_pkg::out_word_t             out_data
);
  import sfd_pkg::*;

  // A waiting input word stays put until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input word changed while waiting");

  // A stalled result word stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Only payload words carry a payload byte and index.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind != EV_PAYLOAD) |->
      (out_data.payload_byte == '0) && (out_data.payload_index == '0))
    else $error("payload fields set on a non-payload word");

  // Checksum and routing flags belong to completed frames only.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind != EV_COMPLETE) |->
      !out_data.checksum_ok && !out_data.to_response)
    else $error("completion flags set on a word that is not a completed frame");

  // Reset empties the output buffer and opens the input.
  assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("buffer not empty after reset");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (.*);
